### rtl/core/shape_pair_overlap_test_unit_defines.svh
// Assertion macros for the shape pair overlap test unit.
`ifndef SHAPE_PAIR_OVERLAP_TEST_UNIT_DEFINES_SVH
`define SHAPE_PAIR_OVERLAP_TEST_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SPO_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("shape pair overlap assertion failed");
`define SPO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
		else $error("shape pair overlap assertion failed");
`else
`define SPO_ASSERT(label, clk, rst_n, prop)
`define SPO_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/spo_pkg.sv
// Shared shape codes and control types of the shape pair overlap test unit.
package spo_pkg;
	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_CIRCLE  = 2'd1;
	localparam logic [1:0] KIND_RECT    = 2'd2;
	localparam logic [1:0] KIND_ELLIPSE = 2'd3;

	typedef struct packed {
		logic use_mul;
		logic pre_hit;
		logic strict;
	} spo_ctrl_t;
endpackage

### rtl/core/spo_geom.sv
// Front stages: centre differences, pair decode and operands of the unit-circle compare.
module spo_geom #(
	parameter int CB = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  logic [1:0]            shape_a,
	input  logic signed [CB-1:0]  pos_a_x,
	input  logic signed [CB-1:0]  pos_a_y,
	input  logic [CB-1:0]         width_a,
	input  logic [CB-1:0]         height_a,
	input  logic [CB-2:0]         radius_a,
	input  logic [1:0]            shape_b,
	input  logic signed [CB-1:0]  pos_b_x,
	input  logic signed [CB-1:0]  pos_b_y,
	input  logic [CB-1:0]         width_b,
	input  logic [CB-1:0]         height_b,
	input  logic [CB-2:0]         radius_b,
	output logic                  vld_s2,
	output spo_pkg::spo_ctrl_t    ctrl_s2,
	output logic [CB+1:0]         px_s2,
	output logic [CB+1:0]         py_s2,
	output logic [CB+1:0]         sx_s2,
	output logic [CB+1:0]         sy_s2
);
	import spo_pkg::*;

	localparam int OW = CB + 2;

	localparam logic [2:0] PAIR_NONE = 3'd0;
	localparam logic [2:0] PAIR_CC   = 3'd1;
	localparam logic [2:0] PAIR_RR   = 3'd2;
	localparam logic [2:0] PAIR_EE   = 3'd3;
	localparam logic [2:0] PAIR_CR   = 3'd4;
	localparam logic [2:0] PAIR_CE   = 3'd5;
	localparam logic [2:0] PAIR_ER   = 3'd6;

	logic signed [CB:0] dx, dy;
	logic [CB:0]        adx, ady;
	logic [2:0]         pair;

	logic          vld_s1;
	logic [2:0]    pair_s1;
	logic [CB:0]   adx_s1, ady_s1;
	logic          dxnz_s1, dynz_s1;
	logic [CB-2:0] rc_s1;
	logic [CB-1:0] rsum_s1;
	logic [CB-1:0] rw_s1, rh_s1, ew_s1, eh_s1;
	logic [CB:0]   wsum_s1, hsum_s1;

	assign dx  = (CB+1)'(pos_a_x) - (CB+1)'(pos_b_x);
	assign dy  = (CB+1)'(pos_a_y) - (CB+1)'(pos_b_y);
	assign adx = dx[CB] ? (CB+1)'(-dx) : (CB+1)'(dx);
	assign ady = dy[CB] ? (CB+1)'(-dy) : (CB+1)'(dy);

	always_comb begin
		unique case ({shape_a, shape_b})
			{KIND_CIRCLE, KIND_CIRCLE}:   pair = PAIR_CC;
			{KIND_RECT, KIND_RECT}:       pair = PAIR_RR;
			{KIND_ELLIPSE, KIND_ELLIPSE}: pair = PAIR_EE;
			{KIND_CIRCLE, KIND_RECT},
			{KIND_RECT, KIND_CIRCLE}:     pair = PAIR_CR;
			{KIND_CIRCLE, KIND_ELLIPSE},
			{KIND_ELLIPSE, KIND_CIRCLE}:  pair = PAIR_CE;
			{KIND_ELLIPSE, KIND_RECT},
			{KIND_RECT, KIND_ELLIPSE}:    pair = PAIR_ER;
			default:                      pair = PAIR_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		pair_s1 <= pair;
		adx_s1  <= adx;
		ady_s1  <= ady;
		dxnz_s1 <= (dx != '0);
		dynz_s1 <= (dy != '0);
		rc_s1   <= (shape_a == KIND_CIRCLE) ? radius_a : radius_b;
		rsum_s1 <= CB'(radius_a) + CB'(radius_b);
		rw_s1   <= (shape_a == KIND_RECT) ? width_a : width_b;
		rh_s1   <= (shape_a == KIND_RECT) ? height_a : height_b;
		ew_s1   <= (shape_a == KIND_ELLIPSE) ? width_a : width_b;
		eh_s1   <= (shape_a == KIND_ELLIPSE) ? height_a : height_b;
		wsum_s1 <= (CB+1)'(width_a) + (CB+1)'(width_b);
		hsum_s1 <= (CB+1)'(height_a) + (CB+1)'(height_b);
	end

	// Centres are compared at twice their value so that half sizes need no shift.
	logic [OW-1:0]      ad2x, ad2y, two_r;
	logic signed [OW:0] tx, ty;
	logic [OW-1:0]      atx, aty, ctx, cty;
	logic               inside_tall, inside_wide, rr_hit;
	spo_ctrl_t          ctrl;
	logic [OW-1:0]      px, py, sx, sy;

	assign ad2x  = {adx_s1, 1'b0};
	assign ad2y  = {ady_s1, 1'b0};
	assign two_r = OW'({rc_s1, 1'b0});
	assign tx    = $signed({1'b0, ad2x}) - $signed({3'b000, rw_s1});
	assign ty    = $signed({1'b0, ad2y}) - $signed({3'b000, rh_s1});
	assign atx   = tx[OW] ? OW'(-tx) : OW'(tx);
	assign aty   = ty[OW] ? OW'(-ty) : OW'(ty);
	assign ctx   = tx[OW] ? '0 : OW'(tx);
	assign cty   = ty[OW] ? '0 : OW'(ty);

	assign inside_tall = (ad2x < OW'(rw_s1)) && (ad2y < OW'(rh_s1) + two_r);
	assign inside_wide = (ad2x < OW'(rw_s1) + two_r) && (ad2y < OW'(rh_s1));
	assign rr_hit      = (ad2x < OW'(wsum_s1)) && (ad2y < OW'(hsum_s1));

	always_comb begin
		ctrl = '0;
		px   = ad2x;
		py   = ad2y;
		sx   = '0;
		sy   = '0;
		case (pair_s1)
			PAIR_CC: begin
				// Both sides are scaled by the squared radius sum, which keeps the strict test.
				ctrl.use_mul = 1'b1;
				ctrl.strict  = 1'b1;
				sx = OW'({rsum_s1, 1'b0});
				sy = OW'({rsum_s1, 1'b0});
			end
			PAIR_RR: begin
				ctrl.pre_hit = rr_hit;
			end
			PAIR_EE: begin
				ctrl.use_mul = 1'b1;
				sx = OW'(wsum_s1);
				sy = OW'(hsum_s1);
			end
			PAIR_CE: begin
				ctrl.use_mul = 1'b1;
				sx = OW'(ew_s1) + two_r;
				sy = OW'(eh_s1) + two_r;
			end
			PAIR_ER: begin
				ctrl.use_mul = 1'b1;
				px = ctx;
				py = cty;
				sx = OW'(ew_s1);
				sy = OW'(eh_s1);
			end
			PAIR_CR: begin
				// The corner test is skipped when the centres share an axis.
				ctrl.pre_hit = inside_tall || inside_wide;
				ctrl.use_mul = dxnz_s1 && dynz_s1;
				ctrl.strict  = 1'b1;
				px = atx;
				py = aty;
				sx = two_r;
				sy = two_r;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctrl_s2 <= ctrl;
		px_s2   <= px;
		py_s2   <= py;
		sx_s2   <= sx;
		sy_s2   <= sy;
	end
endmodule

### rtl/core/spo_wmul.sv
// Two-stage wide unsigned multiplier built from four registered partial products.
module spo_wmul #(
	parameter int W = 36
) (
	input  logic           clk,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [2*W-1:0] p_s5
);
	localparam int L = W / 2;
	localparam int H = W - L;

	logic [2*L-1:0] pll_s4;
	logic [L+H-1:0] plh_s4, phl_s4;
	logic [2*H-1:0] phh_s4;

	always_ff @(posedge clk) begin
		pll_s4 <= (2*L)'(a[L-1:0]) * (2*L)'(b[L-1:0]);
		plh_s4 <= (L+H)'(a[L-1:0]) * (L+H)'(b[W-1:L]);
		phl_s4 <= (L+H)'(a[W-1:L]) * (L+H)'(b[L-1:0]);
		phh_s4 <= (2*H)'(a[W-1:L]) * (2*H)'(b[W-1:L]);
	end

	always_ff @(posedge clk) begin
		p_s5 <= {phh_s4, pll_s4} + ((2*W)'(plh_s4) << L) + ((2*W)'(phl_s4) << L);
	end
endmodule

### rtl/core/spo_cmp.sv
// Back stages: squares, wide cross products and the final unit-circle compare.
module spo_cmp #(
	parameter int OW = 18
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_s2,
	input  spo_pkg::spo_ctrl_t ctrl_s2,
	input  logic [OW-1:0]      px_s2,
	input  logic [OW-1:0]      py_s2,
	input  logic [OW-1:0]      sx_s2,
	input  logic [OW-1:0]      sy_s2,
	output logic               vld_s6,
	output logic               hit_s6
);
	import spo_pkg::*;

	localparam int QW = 2 * OW;
	localparam int PW = 2 * QW;

	logic          vld_s3, vld_s4, vld_s5;
	spo_ctrl_t     ctrl_s3, ctrl_s4, ctrl_s5;
	logic          nz_s3, nz_s4, nz_s5;
	logic [QW-1:0] px2_s3, py2_s3, sx2_s3, sy2_s3;
	logic [PW-1:0] pa_s5, pb_s5, pr_s5;
	logic [PW:0]   lhs, rhs;
	logic          cmp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		px2_s3  <= QW'(px_s2) * QW'(px_s2);
		py2_s3  <= QW'(py_s2) * QW'(py_s2);
		sx2_s3  <= QW'(sx_s2) * QW'(sx_s2);
		sy2_s3  <= QW'(sy_s2) * QW'(sy_s2);
		nz_s3   <= (sx_s2 != '0) && (sy_s2 != '0);
		ctrl_s3 <= ctrl_s2;
		nz_s4   <= nz_s3;
		ctrl_s4 <= ctrl_s3;
		nz_s5   <= nz_s4;
		ctrl_s5 <= ctrl_s4;
	end

	// (px/sx)^2 + (py/sy)^2 against one, with both sides multiplied by sx^2 * sy^2.
	spo_wmul #(.W(QW)) u_mul_a (.clk(clk), .a(px2_s3), .b(sy2_s3), .p_s5(pa_s5));
	spo_wmul #(.W(QW)) u_mul_b (.clk(clk), .a(py2_s3), .b(sx2_s3), .p_s5(pb_s5));
	spo_wmul #(.W(QW)) u_mul_r (.clk(clk), .a(sx2_s3), .b(sy2_s3), .p_s5(pr_s5));

	assign lhs = (PW+1)'(pa_s5) + (PW+1)'(pb_s5);
	assign rhs = (PW+1)'(pr_s5);
	assign cmp = ctrl_s5.strict ? (lhs < rhs) : (lhs <= rhs);

	always_ff @(posedge clk) begin
		hit_s6 <= ctrl_s5.pre_hit || (ctrl_s5.use_mul && nz_s5 && cmp);
	end
endmodule

### rtl/core/shape_pair_overlap_test_unit.sv
// Top level of the shape pair overlap test unit.
//
//  channel  | handshake      | fields
//  request  | start, busy    | shape_a, pos_a_x/y, width_a, height_a, radius_a, same for b
//  result   | done (strobe)  | hit
//
// One request is taken in every cycle; busy stays low.
// Each request passes through two geometry stages,
// one squaring stage and a two-stage split multiplier ahead of the final compare.
// Reset clears only the valid bits of the six stages; no result is lost or repeated.
// The result is shown for one cycle and the receiver cannot hold it off.
`include "shape_pair_overlap_test_unit_defines.svh"
module shape_pair_overlap_test_unit #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   shape_a,
	input  logic signed [COORD_BITS-1:0] pos_a_x,
	input  logic signed [COORD_BITS-1:0] pos_a_y,
	input  logic [COORD_BITS-1:0]        width_a,
	input  logic [COORD_BITS-1:0]        height_a,
	input  logic [COORD_BITS-2:0]        radius_a,
	input  logic [1:0]                   shape_b,
	input  logic signed [COORD_BITS-1:0] pos_b_x,
	input  logic signed [COORD_BITS-1:0] pos_b_y,
	input  logic [COORD_BITS-1:0]        width_b,
	input  logic [COORD_BITS-1:0]        height_b,
	input  logic [COORD_BITS-2:0]        radius_b,
	output logic                         done,
	output logic                         hit
);
	import spo_pkg::*;

	localparam int OW  = COORD_BITS + 2;
	localparam int LAT = 6;

	logic          vld_s2;
	spo_ctrl_t     ctrl_s2;
	logic [OW-1:0] px_s2, py_s2, sx_s2, sy_s2;

	assign busy = 1'b0;

	spo_geom #(.CB(COORD_BITS)) u_geom (
		.clk(clk), .arst_n(arst_n), .in_vld(start && !busy),
		.shape_a(shape_a), .pos_a_x(pos_a_x), .pos_a_y(pos_a_y),
		.width_a(width_a), .height_a(height_a), .radius_a(radius_a),
		.shape_b(shape_b), .pos_b_x(pos_b_x), .pos_b_y(pos_b_y),
		.width_b(width_b), .height_b(height_b), .radius_b(radius_b),
		.vld_s2(vld_s2), .ctrl_s2(ctrl_s2),
		.px_s2(px_s2), .py_s2(py_s2), .sx_s2(sx_s2), .sy_s2(sy_s2)
	);

	spo_cmp #(.OW(OW)) u_cmp (
		.clk(clk), .arst_n(arst_n), .vld_s2(vld_s2), .ctrl_s2(ctrl_s2),
		.px_s2(px_s2), .py_s2(py_s2), .sx_s2(sx_s2), .sy_s2(sy_s2),
		.vld_s6(done), .hit_s6(hit)
	);

	`SPO_ASSERT(a_done_has_request, clk, arst_n, done |-> $past(start, LAT))
	`SPO_ASSERT(a_no_shape_no_hit, clk, arst_n, (done && hit) |-> ($past(shape_a, LAT) != KIND_NONE && $past(shape_b, LAT) != KIND_NONE))
	`SPO_ASSERT(a_concentric_circles, clk, arst_n, (done && $past(shape_a == KIND_CIRCLE && shape_b == KIND_CIRCLE && pos_a_x == pos_b_x && pos_a_y == pos_b_y && (radius_a != '0 || radius_b != '0), LAT)) |-> hit)
	`SPO_ASSERT_NEXT(a_never_busy, clk, arst_n, start, !busy)
endmodule
